// File: src/mtss_pkg.sv
// Shared types, constants and codes of the monomial term set store.
package mtss_pkg;

  // Largest variable count the store is sized for.
  localparam int MaxVars   = 16;
  localparam int TermDepth = MaxVars + MaxVars * MaxVars + MaxVars * MaxVars * MaxVars;

  // Field widths fixed by the interface.
  localparam int OpW   = 2;
  localparam int NameW = 5;
  localparam int CntW  = 5;
  localparam int DegW  = 2;

  // Derived widths.
  localparam int NumW  = $clog2(MaxVars + 1);
  localparam int OffW  = $clog2(MaxVars);
  localparam int IdxW  = $clog2(TermDepth);
  localparam int CmpW  = (NameW > NumW) ? ((NameW > CntW) ? NameW : CntW)
                                        : ((NumW > CntW) ? NumW : CntW);

  localparam logic [CntW-1:0] VarCountRst = CntW'(16);

  typedef enum logic [OpW-1:0] {
    OpTest  = 2'd0,
    OpSet   = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul1,
    StMul2,
    StRead,
    StWrite
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [NameW-1:0] var_a;
    logic [NameW-1:0] var_b;
    logic [NameW-1:0] var_c;
  } in_item_t;

  typedef struct packed {
    logic            was_present;
    logic            changed;
    logic [DegW-1:0] term_degree;
    logic            bad_term;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic rd;
    logic finish;
    logic clr_wr;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

// File: src/mtss_in_if.sv
// Input channel: one term request per transfer.
interface mtss_in_if;
  logic                valid;
  logic                ready;
  mtss_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/mtss_out_if.sv
// Output channel: one result per transfer.
interface mtss_out_if;
  logic                valid;
  logic                ready;
  mtss_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/mtss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtss_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mtss_ctrl.sv
// Sequencer: clearing sweep, then load / two multiply steps / read / write per item.
module mtss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mtss_pkg::status_t status_i,
  output mtss_pkg::cmd_t    cmd_o
);

  mtss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtss_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mtss_pkg::StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = mtss_pkg::StIdle;
        end
      end
      mtss_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mtss_pkg::StMul1;
        end
      end
      mtss_pkg::StMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = mtss_pkg::StMul2;
      end
      mtss_pkg::StMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = mtss_pkg::StRead;
      end
      mtss_pkg::StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = mtss_pkg::StWrite;
      end
      mtss_pkg::StWrite: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = mtss_pkg::StIdle;
        end
      end
      default: begin
        state_d = mtss_pkg::StIdle;
      end
    endcase
  end

endmodule

// File: src/mtss_dp.sv
// Datapath: canonical term, index arithmetic, bit store and result register.
module mtss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mtss_pkg::CntW-1:0]     cfg_data_i,
  input  mtss_pkg::in_item_t            in_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output mtss_pkg::out_item_t           out_data_o,
  input  mtss_pkg::cmd_t                cmd_i,
  output mtss_pkg::status_t             status_o
);

  localparam int KeyW = mtss_pkg::NameW + 1;
  localparam int IdxW = mtss_pkg::IdxW;
  localparam int OffW = mtss_pkg::OffW;
  localparam int NumW = mtss_pkg::NumW;
  localparam int CmpW = mtss_pkg::CmpW;

  logic [mtss_pkg::CntW-1:0] var_count_q;

  logic [mtss_pkg::OpW-1:0]  op_q;
  logic [NumW-1:0]           n_q;
  logic                      bad_q;
  logic [mtss_pkg::DegW-1:0] deg_q;
  logic [OffW-1:0]           u0_q, u1_q, u2_q;
  logic [IdxW-1:0]           t_q, idx_q;
  logic [IdxW-1:0]           clr_cnt_q;
  logic                      out_valid_q;
  mtss_pkg::out_item_t       out_q;

  // Canonical form of the incoming term.
  logic [NumW-1:0]           n_c;
  logic                      bad_c;
  logic [mtss_pkg::DegW-1:0] deg_c;
  logic [OffW-1:0]           u0_c, u1_c, u2_c;

  logic                      prev;
  logic                      chg;
  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr;
  logic                      ram_wdata;

  always_comb begin
    logic [KeyW-1:0] k0, k1, k2, tmp;
    logic            v1, v2, over;
    tmp = '0;
    // Saturate the count.
    if (CmpW'(var_count_q) > CmpW'(mtss_pkg::MaxVars)) begin
      n_c = NumW'(mtss_pkg::MaxVars);
    end else begin
      n_c = NumW'(var_count_q);
    end
    over = (CmpW'(in_data_i.var_a) > CmpW'(n_c)) ||
           (CmpW'(in_data_i.var_b) > CmpW'(n_c)) ||
           (CmpW'(in_data_i.var_c) > CmpW'(n_c));
    // Absent names get the top key bit so they sort last.
    k0 = {in_data_i.var_a == '0, in_data_i.var_a};
    k1 = {in_data_i.var_b == '0, in_data_i.var_b};
    k2 = {in_data_i.var_c == '0, in_data_i.var_c};
    if (k0 > k1) begin tmp = k0; k0 = k1; k1 = tmp; end
    if (k1 > k2) begin tmp = k1; k1 = k2; k2 = tmp; end
    if (k0 > k1) begin tmp = k0; k0 = k1; k1 = tmp; end
    v1    = !k1[KeyW-1] && (k1 != k0);
    v2    = !k2[KeyW-1] && (k2 != k1);
    bad_c = over || k0[KeyW-1];
    deg_c = mtss_pkg::DegW'(1) + mtss_pkg::DegW'(v1) + mtss_pkg::DegW'(v2);
    u0_c  = OffW'(k0[mtss_pkg::NameW-1:0] - mtss_pkg::NameW'(1));
    u1_c  = v1 ? OffW'(k1[mtss_pkg::NameW-1:0] - mtss_pkg::NameW'(1))
               : OffW'(k2[mtss_pkg::NameW-1:0] - mtss_pkg::NameW'(1));
    u2_c  = OffW'(k2[mtss_pkg::NameW-1:0] - mtss_pkg::NameW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= mtss_pkg::VarCountRst;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        var_count_q <= cfg_data_i;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + IdxW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.op;
      n_q   <= n_c;
      bad_q <= bad_c;
      deg_q <= deg_c;
      u0_q  <= u0_c;
      u1_q  <= u1_c;
      u2_q  <= u2_c;
    end
    // t = n*(a+1) + b : the degree-two index
    if (cmd_i.mul1) begin
      t_q <= IdxW'(n_q) * (IdxW'(u0_q) + IdxW'(1)) + IdxW'(u1_q);
    end
    // final index: a for degree one, t for degree two, n*(t+1) + c for degree three
    if (cmd_i.mul2) begin
      unique case (deg_q)
        2'd1:    idx_q <= IdxW'(u0_q);
        2'd2:    idx_q <= t_q;
        default: idx_q <= IdxW'(n_q) * (t_q + IdxW'(1)) + IdxW'(u2_q);
      endcase
    end
    if (cmd_i.finish) begin
      if (bad_q) begin
        out_q <= '{was_present: 1'b0, changed: 1'b0, term_degree: '0, bad_term: 1'b1};
      end else begin
        out_q <= '{was_present: prev, changed: chg, term_degree: deg_q, bad_term: 1'b0};
      end
    end
  end

  always_comb begin
    chg = 1'b0;
    if (op_q == mtss_pkg::OpSet) begin
      chg = !prev;
    end else if (op_q == mtss_pkg::OpClear) begin
      chg = prev;
    end
  end

  assign ram_we    = cmd_i.clr_wr || (cmd_i.finish && !bad_q && chg);
  assign ram_waddr = cmd_i.clr_wr ? clr_cnt_q : idx_q;
  assign ram_wdata = cmd_i.clr_wr ? 1'b0 : !prev;

  mtss_ram #(
    .Width (1),
    .Depth (mtss_pkg::TermDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd && !bad_q),
    .raddr_i (idx_q),
    .rdata_o (prev)
  );

  assign status_o.clr_last = (clr_cnt_q == IdxW'(mtss_pkg::TermDepth - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// File: src/monomial_term_set_store_core.sv
// Top level of the monomial term set store: controller, datapath and checks.
//
// Keeps one bit for every monomial of degree one to three over up to 16
// variables (16 + 16^2 + 16^3 = 4368 bits). Each input transfer names up to
// three 1-based variables (0 = absent) and an op: test, set or clear. The term
// is made canonical (absent names dropped, names sorted, repeats merged) and
// mapped to a bit index scaled by var_count (saturated to 16). One result
// transfer comes back per item with prior presence, a changed flag, the
// canonical degree, and bad_term for an empty term or a name above the count;
// a bad term never touches the store. After reset the store is swept to zero
// with in_i.ready low; var_count writes are taken during it. An item goes from
// accept to result: canonicalize on accept, two dependent multiply steps of the
// index, the RAM's registered read, and the write-back with the result load. A
// waiting result is held in an output register; the next item is accepted as
// soon as the previous one is written back. The user sees that var_count is
// written only while idle (not enforced); a write does not clear the store.
module monomial_term_set_store_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mtss_pkg::CntW-1:0] cfg_data_i,
  mtss_in_if.sink                   in_i,
  mtss_out_if.source                out_o
);

  mtss_pkg::cmd_t    cmd;
  mtss_pkg::status_t status;

  mtss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mtss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // One item in flight: an accepted transfer drops ready on the next cycle.
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while an item is in flight");

  // A rejected term reports nothing else.
  a_bad_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.bad_term) |->
      (!out_o.data.was_present && !out_o.data.changed && out_o.data.term_degree == '0))
    else $error("bad term result carries data");

  // A good term has a degree of one to three.
  a_good_degree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.bad_term) |-> (out_o.data.term_degree != '0))
    else $error("accepted term with zero degree");

  // No result is produced during the clearing sweep.
  a_no_result_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> (!out_o.valid && !in_i.ready))
    else $error("traffic during the clearing sweep");

endmodule

// File: tb/monomial_term_set_store_core_test.sv
// Self-checking testbench for the monomial term set store core.
module monomial_term_set_store_core_test;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 8;
  // Margin after the last result is seen.
  localparam int SettleCycles = 10;
  localparam int HoldCycles   = 300;
  // Bound on a correct run: the clear sweep, then ~1950 items with sender gaps
  // and receiver stalls, plus the long stall and drain pauses.
  localparam int CycleLimit   = 400000;
  localparam int PhaseCount   = 8;
  localparam int MaxReports   = 40;
  // Absent names sort behind every real name.
  localparam int unsigned NoName = 255;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [mtss_pkg::CntW-1:0] cfg_data;

  mtss_in_if  req_ch ();
  mtss_out_if rsp_ch ();

  monomial_term_set_store_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (req_ch),
    .out_o      (rsp_ch)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Mirror of the store, updated at each input transfer, and of var_count, updated at each write.
  logic                      term_mirror [mtss_pkg::TermDepth] = '{default: 1'b0};
  logic [mtss_pkg::CntW-1:0] live_count = mtss_pkg::VarCountRst;

  mtss_pkg::in_item_t  request_backlog [$];
  mtss_pkg::out_item_t results_due [$];

  int unsigned requests_queued = 0;
  int unsigned replies_seen    = 0;
  int unsigned mismatches      = 0;
  int unsigned rejected_seen   = 0;
  int unsigned flips_seen      = 0;
  int unsigned count_writes    = 0;
  int unsigned tx_idle_pct     = 0;
  int unsigned rx_stall_pct    = 0;
  int unsigned hold_asks       = 0;
  int unsigned hold_taken      = 0;
  int unsigned hold_left       = 0;
  int unsigned cycle_count     = 0;

  // var_count per random phase; 0, 1, 16 and 31 are the extremes.
  logic [mtss_pkg::CntW-1:0] phase_vars [PhaseCount] =
    '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd2, 5'd16, 5'd11};
  int unsigned     phase_counts [PhaseCount] = '{300, 150, 300, 30, 300, 250, 300, 300};

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Canonicalize the term, map it to its bit and apply the op to the mirror.
  function automatic mtss_pkg::out_item_t resolve_term(mtss_pkg::in_item_t req);
    int unsigned                n;
    int unsigned                idx;
    int unsigned                tmp;
    int unsigned                deg;
    int unsigned                key [3];
    int unsigned                uniq [3];
    logic                       reject;
    logic [mtss_pkg::IdxW-1:0]  bit_idx;
    mtss_pkg::out_item_t        res;
    n      = (32'(live_count) > mtss_pkg::MaxVars) ? mtss_pkg::MaxVars : 32'(live_count);
    key[0] = 32'(req.var_a);
    key[1] = 32'(req.var_b);
    key[2] = 32'(req.var_c);
    reject = (key[0] > n) || (key[1] > n) || (key[2] > n);
    for (int i = 0; i < 3; i++)
      if (key[i] == 0) key[i] = NoName;
    // three-element sorting network
    if (key[0] > key[1]) begin tmp = key[0]; key[0] = key[1]; key[1] = tmp; end
    if (key[1] > key[2]) begin tmp = key[1]; key[1] = key[2]; key[2] = tmp; end
    if (key[0] > key[1]) begin tmp = key[0]; key[0] = key[1]; key[1] = tmp; end
    // drop absent names, merge repeats, go 0-based
    deg = 0;
    idx = 0;
    for (int i = 0; i < 3; i++)
      if (key[i] != NoName && (deg == 0 || uniq[deg-1] != key[i] - 1)) begin
        uniq[deg] = key[i] - 1;
        deg++;
      end
    if (deg == 0) reject = 1'b1;
    res = '0;
    if (!reject) begin
      case (deg)
        1: idx = uniq[0];
        2: idx = n + n * uniq[0] + uniq[1];
        default: idx = n + n * n + n * n * uniq[0] + n * uniq[1] + uniq[2];
      endcase
      if (idx >= mtss_pkg::TermDepth) reject = 1'b1;
    end
    bit_idx = mtss_pkg::IdxW'(idx);
    if (reject) begin
      res.bad_term = 1'b1;
    end else begin
      res.was_present = term_mirror[bit_idx];
      res.term_degree = mtss_pkg::DegW'(deg);
      if (req.op == mtss_pkg::OpSet && !term_mirror[bit_idx]) begin
        term_mirror[bit_idx] = 1'b1;
        res.changed          = 1'b1;
      end else if (req.op == mtss_pkg::OpClear && term_mirror[bit_idx]) begin
        term_mirror[bit_idx] = 1'b0;
        res.changed          = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [mtss_pkg::NameW-1:0] pick_name(int unsigned lo, int unsigned hi);
    return ($urandom_range(99) < 15) ? '0 : mtss_pkg::NameW'($urandom_range(hi, lo));
  endfunction

  // Mostly names from a narrow window so terms recur; some full-range terms,
  // some noise with names above any count and the unused op.
  function automatic mtss_pkg::in_item_t roll_request(int unsigned lo, int unsigned hi);
    mtss_pkg::in_item_t r;
    int unsigned        pick;
    pick = $urandom_range(99);
    r.op = mtss_pkg::OpW'($urandom_range(mtss_pkg::OpClear, mtss_pkg::OpTest));
    if (pick < 65) begin
      r.var_a = pick_name(lo, hi);
      r.var_b = pick_name(lo, hi);
      r.var_c = pick_name(lo, hi);
    end else if (pick < 92) begin
      r.var_a = pick_name(1, mtss_pkg::MaxVars);
      r.var_b = pick_name(1, mtss_pkg::MaxVars);
      r.var_c = pick_name(1, mtss_pkg::MaxVars);
    end else begin
      r.op    = mtss_pkg::OpW'($urandom_range(mtss_pkg::OpNone, mtss_pkg::OpTest));
      r.var_a = mtss_pkg::NameW'($urandom_range(31));
      r.var_b = mtss_pkg::NameW'($urandom_range(31));
      r.var_c = mtss_pkg::NameW'($urandom_range(31));
    end
    return r;
  endfunction

  task automatic queue_item(mtss_pkg::in_item_t r);
    request_backlog.push_back(r);
    requests_queued++;
  endtask

  task automatic write_count(logic [mtss_pkg::CntW-1:0] v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    live_count = v;
    count_writes++;
  endtask

  // Sender holds back until every queued request has its result back.
  task automatic drain_results();
    while (replies_seen < requests_queued) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Request driver: predicts at each input transfer, then offers the next item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        results_due.push_back(resolve_term(req_ch.data));
      if (!req_ch.valid || req_ch.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data  <= request_backlog.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long output stall, counted here once the stimulus asks for it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_taken <= 0;
      hold_left  <= 0;
    end else if (hold_asks != hold_taken) begin
      hold_taken <= hold_asks;
      hold_left  <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: every transfer is checked against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    mtss_pkg::out_item_t due;
    mtss_pkg::out_item_t got;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (results_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          due = results_due.pop_front();
          if (got.was_present !== due.was_present)
            report_mismatch($sformatf("was_present %b, predicted %b",
                                      got.was_present, due.was_present));
          if (got.changed !== due.changed)
            report_mismatch($sformatf("changed %b, predicted %b",
                                      got.changed, due.changed));
          if (got.term_degree !== due.term_degree)
            report_mismatch($sformatf("term_degree %0d, predicted %0d",
                                      got.term_degree, due.term_degree));
          if (got.bad_term !== due.bad_term)
            report_mismatch($sformatf("bad_term %b, predicted %b",
                                      got.bad_term, due.bad_term));
          if (due.bad_term) rejected_seen++;
          if (due.changed) flips_seen++;
          replies_seen++;
        end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned n_eff;
    int unsigned lo;
    int unsigned hi;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Taken during the clear sweep; the driver waits on ready meanwhile.
    write_count(5'd16);

    // Directed: reorderings, repeats, empty terms, extremes, unused op.
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd1,  5'd2,  5'd3});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd3,  5'd2,  5'd1});   // already present
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpTest,  5'd2,  5'd1,  5'd3});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpClear, 5'd1,  5'd3,  5'd2});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpClear, 5'd1,  5'd2,  5'd3});   // already absent
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpTest,  5'd0,  5'd0,  5'd0});   // empty term
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd0,  5'd0,  5'd0});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd16, 5'd16, 5'd16});  // merges to degree 1
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpTest,  5'd16, 5'd0,  5'd0});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd5,  5'd5,  5'd9});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpTest,  5'd9,  5'd0,  5'd5});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd0,  5'd7,  5'd0});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpNone,  5'd7,  5'd0,  5'd0});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpNone,  5'd16, 5'd0,  5'd0});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd17, 5'd1,  5'd2});   // name above count
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd31, 5'd31, 5'd31});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd16, 5'd15, 5'd14});  // top of the layout
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpTest,  5'd14, 5'd16, 5'd15});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpClear, 5'd16, 5'd16, 5'd16});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd1,  5'd0,  5'd0});   // bit zero
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpSet,   5'd1,  5'd1,  5'd2});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpClear, 5'd0,  5'd0,  5'd1});
    queue_item(mtss_pkg::in_item_t'{mtss_pkg::OpTest,  5'd2,  5'd1,  5'd1});
    drain_results();

    // Random phases; the store is never cleared, so every count change
    // reads old bits through a new layout.
    for (int p = 0; p < PhaseCount; p++) begin
      write_count(phase_vars[p]);
      n_eff = (32'(phase_vars[p]) > mtss_pkg::MaxVars) ? mtss_pkg::MaxVars
                                                       : 32'(phase_vars[p]);
      if (n_eff == 0) begin
        lo = 1;
        hi = 1;
      end else begin
        lo = $urandom_range((n_eff > 3) ? n_eff - 3 : 1, 1);
        hi = (lo + 3 > n_eff) ? n_eff : lo + 3;
      end
      @(posedge clk_i);
      case (p % 4)
        0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct <= 57; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct <= 0;  rx_stall_pct <= 57; end
        default: begin tx_idle_pct <= 16; rx_stall_pct <= 16; end
      endcase
      // First phase: output held off while the sender keeps offering.
      if (p == 0) hold_asks <= hold_asks + 1;
      for (int i = 0; i < phase_counts[p] / 2; i++) queue_item(roll_request(lo, hi));
      drain_results();
      for (int i = phase_counts[p] / 2; i < phase_counts[p]; i++)
        queue_item(roll_request(lo, hi));
      drain_results();
    end

    $display("Checked %0d term results across %0d var_count writes (0, 1, 16, 31 included).",
             replies_seen, count_writes);
    $display("%0d rejected terms, %0d store updates, a %0d-cycle output stall, four idle mixes.",
             rejected_seen, flips_seen, HoldCycles);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: monomial_term_set_store_core.f
src/mtss_pkg.sv
src/mtss_in_if.sv
src/mtss_out_if.sv
src/mtss_ram.sv
src/mtss_ctrl.sv
src/mtss_dp.sv
src/monomial_term_set_store_core.sv
tb/monomial_term_set_store_core_test.sv
